// ===== hw/rtl/fssum_pkg.sv =====
// ----------------------------------------------------------------------------
// fssum_pkg
// shared types, codes and constant helpers for the fresnel sine series core
// ----------------------------------------------------------------------------
`default_nettype none

package fssum_pkg;

    // i/o fixed-point format of x_value and series_sum
    localparam int IO_FRAC   = 28;
    // clamp limit of the argument, 2.0 in q4.28
    localparam int X_LIMIT   = 536870912;
    // reset value of the epsilon register
    localparam int EPS_RESET = 268;
    // divisor of the first term, x^3/3
    localparam int FIRST_DIV = 3;
    // multiplier digit size, bits of operand b per cycle
    localparam int DIGIT_W   = 8;

    typedef enum logic [1:0] {
        ALU_MUL_RND,
        ALU_MUL_INT,
        ALU_DIV_RND
    } alu_op_t;

    typedef enum logic [1:0] {
        AST_IDLE,
        AST_MUL,
        AST_DIV,
        AST_DIV_RND
    } alu_state_t;

    typedef enum logic [3:0] {
        SEQ_IDLE,
        SEQ_X2,
        SEQ_X4,
        SEQ_X3,
        SEQ_T0,
        SEQ_CHECK,
        SEQ_TX4,
        SEQ_TCOEF,
        SEQ_TDIV,
        SEQ_DONE
    } seq_state_t;

    typedef struct packed {
        logic    start;
        alu_op_t op;
    } alu_req_t;

    typedef struct packed {
        logic idle;
        logic res_valid;
    } seq_status_t;

    // numerator factor of the term ratio, 4k-1
    function automatic logic [7:0] fssum_coef(input logic [7:0] k);
        logic [9:0] k4;
        k4 = 10'(k) << 2;
        return 8'(k4 - 10'd1);
    endfunction

    // denominator of the term ratio, (2k)(2k+1)(4k+3)
    function automatic logic [31:0] fssum_denom(input logic [7:0] k);
        logic [8:0]  k2;
        logic [8:0]  k2p;
        logic [9:0]  k4p;
        logic [17:0] p1;
        logic [27:0] p2;
        k2  = 9'(k) << 1;
        k2p = k2 + 9'd1;
        k4p = (10'(k) << 2) + 10'd3;
        p1  = 18'(k2) * 18'(k2p);
        p2  = 28'(p1) * 28'(k4p);
        return 32'(p2);
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/fssum_alu.sv =====
// ----------------------------------------------------------------------------
// fssum_alu
// shared multi-cycle unit: digit-serial multiply and radix-2 rounded divide
// ----------------------------------------------------------------------------
`default_nettype none

module fssum_alu #(
    parameter int DW        = 38,
    parameter int FRAC_BITS = 28
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire fssum_pkg::alu_req_t  req,
    input  wire logic [DW-1:0]        a,
    input  wire logic [DW-1:0]        b,
    output logic                      done,
    output logic [DW-1:0]             result
);
    import fssum_pkg::*;

    localparam int PW = 2 * DW;
    localparam int CW = $clog2(DW + 1);
    localparam logic [PW-1:0] HALF = PW'(1) << (FRAC_BITS - 1);

    alu_state_t     state_reg, state_next;
    alu_op_t        op_reg, op_next;
    logic [PW-1:0]  a_reg, a_next;
    logic [DW-1:0]  b_reg, b_next;
    logic [PW-1:0]  acc_reg, acc_next;
    logic [DW-1:0]  rem_reg, rem_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic [DW-1:0]  res_reg, res_next;
    logic           done_reg, done_next;

    logic [PW-1:0]  acc_sum;
    logic [DW:0]    rem_sh;
    logic [DW:0]    dvs;
    logic [DW:0]    rem_sub;
    logic           ge;
    logic           rnd_ge;

    // one digit of b per cycle
    assign acc_sum = acc_reg + a_reg * {{(PW - DIGIT_W){1'b0}}, b_reg[DIGIT_W-1:0]};

    // restoring divide step, dividend shifts out of b_reg, quotient shifts in
    assign dvs     = {1'b0, a_reg[DW-1:0]};
    assign rem_sh  = {rem_reg, b_reg[DW-1]};
    assign ge      = rem_sh >= dvs;
    assign rem_sub = rem_sh - dvs;
    assign rnd_ge  = {rem_reg, 1'b0} >= dvs;

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        acc_next   = acc_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        res_next   = res_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            AST_IDLE:
            begin
                if (req.start)
                begin
                    op_next = req.op;
                    if (req.op == ALU_DIV_RND)
                    begin
                        a_next     = PW'(b);
                        b_next     = a;
                        rem_next   = '0;
                        cnt_next   = CW'(DW);
                        state_next = AST_DIV;
                    end
                    else
                    begin
                        a_next     = PW'(a);
                        b_next     = b;
                        acc_next   = (req.op == ALU_MUL_RND) ? HALF : '0;
                        state_next = AST_MUL;
                    end
                end
            end
            AST_MUL:
            begin
                acc_next = acc_sum;
                a_next   = a_reg << DIGIT_W;
                b_next   = b_reg >> DIGIT_W;
                if ((b_reg >> DIGIT_W) == '0)
                begin
                    state_next = AST_IDLE;
                    done_next  = 1'b1;
                    res_next   = (op_reg == ALU_MUL_RND) ? acc_sum[FRAC_BITS +: DW]
                                                          : acc_sum[DW-1:0];
                end
            end
            AST_DIV:
            begin
                rem_next = ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
                b_next   = {b_reg[DW-2:0], ge};
                cnt_next = cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    state_next = AST_DIV_RND;
                end
            end
            AST_DIV_RND:
            begin
                // round to nearest, ties away from zero
                res_next   = rnd_ge ? b_reg + DW'(1) : b_reg;
                done_next  = 1'b1;
                state_next = AST_IDLE;
            end
            default:
            begin
                state_next = AST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= AST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
        rem_reg <= rem_next;
        cnt_reg <= cnt_next;
        res_reg <= res_next;
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/fssum_seq.sv =====
// ----------------------------------------------------------------------------
// fssum_seq
// series sequencer: powers of x, term recurrence, running sum, stop test
// ----------------------------------------------------------------------------
`default_nettype none

module fssum_seq #(
    parameter int DW        = 38,
    parameter int EW        = 29,
    parameter int KW        = 5,
    parameter int MAX_TERMS = 16
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    input  wire logic [DW-1:0]           x_in,
    input  wire logic                    x_neg_in,
    input  wire logic [EW-1:0]           eps_in,
    input  wire logic                    res_ready,
    output fssum_pkg::seq_status_t       status,
    output logic signed [DW:0]           sum_out,
    output logic [KW-1:0]                k_out,
    output logic                         over_out,
    output fssum_pkg::alu_req_t          alu_req,
    output logic [DW-1:0]                alu_a,
    output logic [DW-1:0]                alu_b,
    input  wire logic                    alu_done,
    input  wire logic [DW-1:0]           alu_res
);
    import fssum_pkg::*;

    seq_state_t         state_reg, state_next;
    logic               pend_reg, pend_next;
    logic [DW-1:0]      x_reg, x_next;
    logic               xneg_reg, xneg_next;
    logic [EW-1:0]      eps_reg, eps_next;
    logic [DW-1:0]      x2_reg, x2_next;
    logic [DW-1:0]      x4_reg, x4_next;
    logic [DW-1:0]      term_reg, term_next;
    logic               tneg_reg, tneg_next;
    logic signed [DW:0] sum_reg, sum_next;
    logic [KW-1:0]      k_reg, k_next;
    logic [DW-1:0]      coef_reg, coef_next;
    logic [DW-1:0]      denom_reg, denom_next;

    logic signed [DW:0] res_s;
    logic               term_big;
    logic [KW-1:0]      k_inc;

    assign res_s    = {1'b0, alu_res};
    assign term_big = term_reg > DW'(eps_reg);
    assign k_inc    = k_reg + KW'(1);

    always_comb
    begin
        state_next = state_reg;
        pend_next  = pend_reg;
        x_next     = x_reg;
        xneg_next  = xneg_reg;
        eps_next   = eps_reg;
        x2_next    = x2_reg;
        x4_next    = x4_reg;
        term_next  = term_reg;
        tneg_next  = tneg_reg;
        sum_next   = sum_reg;
        k_next     = k_reg;
        coef_next  = coef_reg;
        denom_next = denom_reg;
        alu_req.start = 1'b0;
        alu_req.op    = ALU_MUL_RND;
        alu_a         = '0;
        alu_b         = '0;
        status.idle      = 1'b0;
        status.res_valid = 1'b0;
        unique case (state_reg)
            SEQ_IDLE:
            begin
                status.idle = 1'b1;
                if (start)
                begin
                    x_next     = x_in;
                    xneg_next  = x_neg_in;
                    eps_next   = eps_in;
                    state_next = SEQ_X2;
                end
            end
            SEQ_X2:
            begin
                alu_a = x_reg;
                alu_b = x_reg;
                if (alu_done)
                begin
                    x2_next    = alu_res;
                    state_next = SEQ_X4;
                end
            end
            SEQ_X4:
            begin
                alu_a = x2_reg;
                alu_b = x2_reg;
                if (alu_done)
                begin
                    x4_next    = alu_res;
                    state_next = SEQ_X3;
                end
            end
            SEQ_X3:
            begin
                alu_a = x2_reg;
                alu_b = x_reg;
                if (alu_done)
                begin
                    term_next  = alu_res;
                    state_next = SEQ_T0;
                end
            end
            SEQ_T0:
            begin
                alu_req.op = ALU_DIV_RND;
                alu_a      = term_reg;
                alu_b      = DW'(FIRST_DIV);
                if (alu_done)
                begin
                    term_next  = alu_res;
                    tneg_next  = xneg_reg;
                    sum_next   = xneg_reg ? -res_s : res_s;
                    k_next     = '0;
                    state_next = SEQ_CHECK;
                end
            end
            SEQ_CHECK:
            begin
                if (term_big && (k_reg < KW'(MAX_TERMS)))
                begin
                    k_next     = k_inc;
                    coef_next  = DW'(fssum_coef(8'(k_inc)));
                    denom_next = DW'(fssum_denom(8'(k_inc)));
                    state_next = SEQ_TX4;
                end
                else
                begin
                    state_next = SEQ_DONE;
                end
            end
            SEQ_TX4:
            begin
                alu_a = term_reg;
                alu_b = x4_reg;
                if (alu_done)
                begin
                    term_next  = alu_res;
                    state_next = SEQ_TCOEF;
                end
            end
            SEQ_TCOEF:
            begin
                alu_req.op = ALU_MUL_INT;
                alu_a      = term_reg;
                alu_b      = coef_reg;
                if (alu_done)
                begin
                    term_next  = alu_res;
                    state_next = SEQ_TDIV;
                end
            end
            SEQ_TDIV:
            begin
                alu_req.op = ALU_DIV_RND;
                alu_a      = term_reg;
                alu_b      = denom_reg;
                if (alu_done)
                begin
                    // each term flips sign against the one before
                    term_next  = alu_res;
                    tneg_next  = !tneg_reg;
                    sum_next   = tneg_reg ? sum_reg + res_s : sum_reg - res_s;
                    state_next = SEQ_CHECK;
                end
            end
            SEQ_DONE:
            begin
                status.res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = SEQ_IDLE;
                end
            end
            default:
            begin
                state_next = SEQ_IDLE;
            end
        endcase

        // one start per unit operation, cleared when the unit answers
        if ((state_reg == SEQ_X2) || (state_reg == SEQ_X4) || (state_reg == SEQ_X3) ||
            (state_reg == SEQ_T0) || (state_reg == SEQ_TX4) ||
            (state_reg == SEQ_TCOEF) || (state_reg == SEQ_TDIV))
        begin
            alu_req.start = !pend_reg;
            pend_next     = !alu_done;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SEQ_IDLE;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg     <= x_next;
        xneg_reg  <= xneg_next;
        eps_reg   <= eps_next;
        x2_reg    <= x2_next;
        x4_reg    <= x4_next;
        term_reg  <= term_next;
        tneg_reg  <= tneg_next;
        sum_reg   <= sum_next;
        k_reg     <= k_next;
        coef_reg  <= coef_next;
        denom_reg <= denom_next;
    end

    assign sum_out  = sum_reg;
    assign k_out    = k_reg;
    assign over_out = term_big;

endmodule

`default_nettype wire

// ===== hw/rtl/fresnel_sine_series_sum_core.sv =====
// ----------------------------------------------------------------------------
// fresnel_sine_series_sum_core
// fresnel sine integral by its maclaurin series, fixed point, one shared unit
// ----------------------------------------------------------------------------
//
// channel  | signals                        | payload
// ---------+--------------------------------+-----------------------------------
// cfg      | cfg_valid, cfg_ready           | epsilon (q0.28 stop threshold)
// in       | in_valid, in_ready             | x_value (signed q3.28)
// out      | out_valid, out_ready           | series_sum, terms_used, not_converged
//
// one shared multiply/divide unit does all arithmetic on DW = FRAC_BITS+10 bits;
// a multiply steps through operand b by digits and stops once its upper digits
// are zero, and a divide steps through all DW quotient bits and then rounds
// an item takes setup (x^2, x^4, x^3, x^3/3) and hand-off plus a rounded multiply,
// an integer multiply and a divide per added term; x and x^2 fit in four multiply digits
// in_ready is high only while the sequencer is idle
// a finished result moves to the output register and the next item is taken
// while it waits; a full output register stalls the sequencer at its end
// reset clears control state and loads epsilon with its reset value
//
`default_nettype none

module fresnel_sine_series_sum_core #(
    parameter int MAX_TERMS = 16,
    parameter int FRAC_BITS = 28
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    // configuration transaction
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [27:0]        epsilon,
    // input transaction
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic signed [30:0] x_value,
    // output transaction
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [31:0]      series_sum,
    output logic [4:0]              terms_used,
    output logic                    not_converged
);
    import fssum_pkg::*;

    // internal widths: x <= 2, DW keeps ten integer bits for partial products
    localparam int XW  = FRAC_BITS + 2;
    localparam int DW  = FRAC_BITS + 10;
    localparam int EW  = FRAC_BITS + 1;
    localparam int KW  = $clog2(MAX_TERMS + 1);

    // q4.28 to internal scaling
    localparam int X_UP   = (FRAC_BITS >= IO_FRAC) ? FRAC_BITS - IO_FRAC : 0;
    localparam int X_DN   = (FRAC_BITS <  IO_FRAC) ? IO_FRAC - FRAC_BITS : 0;
    localparam int X_DNH  = (X_DN > 0) ? X_DN - 1 : 0;
    localparam int X_HALF = (X_DN > 0) ? (1 << X_DNH) : 0;
    localparam int XCW    = (XW > 31) ? XW : 31;
    localparam int ECW    = (EW > 29) ? EW : 29;

    // internal to q4.28 scaling
    localparam int O_DN   = (FRAC_BITS >= IO_FRAC) ? FRAC_BITS - IO_FRAC : 0;
    localparam int O_UP   = (FRAC_BITS <  IO_FRAC) ? IO_FRAC - FRAC_BITS : 0;
    localparam int O_DNH  = (O_DN > 0) ? O_DN - 1 : 0;
    localparam int O_HALF = (O_DN > 0) ? (1 << O_DNH) : 0;
    localparam int OCW    = DW + 2 + O_UP;

    localparam logic signed [30:0] X_MAX   = 31'(X_LIMIT);
    localparam logic signed [30:0] X_MIN   = -31'(X_LIMIT);
    localparam logic [OCW-1:0]     SAT_POS = OCW'(32'h7FFF_FFFF);
    localparam logic [OCW-1:0]     SAT_NEG = OCW'(32'h8000_0000);

    // configuration register
    logic [27:0] eps_reg;

    // output register
    logic               out_valid_reg, out_valid_next;
    logic signed [31:0] sum_out_reg, sum_out_next;
    logic [4:0]         terms_reg, terms_next;
    logic               nc_reg, nc_next;

    // input conditioning
    logic signed [30:0] x_clamp;
    logic               x_neg;
    logic [30:0]        x_abs;
    logic [XCW-1:0]     x_up;
    logic [XCW-1:0]     x_dn;
    logic [DW-1:0]      x_int;
    logic [ECW-1:0]     e_up;
    logic [ECW-1:0]     e_dn;
    logic [EW-1:0]      eps_int;

    // sequencer and shared unit
    seq_status_t        status;
    alu_req_t           alu_req;
    logic [DW-1:0]      alu_a;
    logic [DW-1:0]      alu_b;
    logic               alu_done;
    logic [DW-1:0]      alu_res;
    logic signed [DW:0] seq_sum;
    logic [KW-1:0]      seq_k;
    logic               seq_over;
    logic               res_ready;
    logic               res_take;

    // result conditioning
    logic               s_neg;
    logic [DW:0]        s_mag;
    logic [OCW-1:0]     o_dn;
    logic [OCW-1:0]     o_up;
    logic [OCW-1:0]     o_mag;
    logic [OCW-1:0]     o_lim;
    logic [OCW-1:0]     o_sat;

    // config transactions are always taken; they must be written only while idle, which the block does not enforce
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eps_reg <= 28'(EPS_RESET);
        end
        else if (cfg_valid && cfg_ready)
        begin
            eps_reg <= epsilon;
        end
    end

    // clamp |x| to 2.0 and split into sign and magnitude
    always_comb
    begin
        priority if (x_value > X_MAX)
        begin
            x_clamp = X_MAX;
        end
        else if (x_value < X_MIN)
        begin
            x_clamp = X_MIN;
        end
        else
        begin
            x_clamp = x_value;
        end
    end

    assign x_neg = x_clamp[30];
    assign x_abs = x_neg ? 31'(-x_clamp) : 31'(x_clamp);

    // rescale x and epsilon, rounding half away from zero on a right shift
    assign x_up    = XCW'(x_abs) << X_UP;
    assign x_dn    = (XCW'(x_abs) + XCW'(X_HALF)) >> X_DN;
    assign x_int   = DW'((FRAC_BITS >= IO_FRAC) ? x_up : x_dn);
    assign e_up    = ECW'(eps_reg) << X_UP;
    assign e_dn    = (ECW'(eps_reg) + ECW'(X_HALF)) >> X_DN;
    assign eps_int = EW'((FRAC_BITS >= IO_FRAC) ? e_up : e_dn);

    assign in_ready = status.idle;

    fssum_seq #(
        .DW        (DW),
        .EW        (EW),
        .KW        (KW),
        .MAX_TERMS (MAX_TERMS)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (in_valid && in_ready),
        .x_in      (x_int),
        .x_neg_in  (x_neg),
        .eps_in    (eps_int),
        .res_ready (res_ready),
        .status    (status),
        .sum_out   (seq_sum),
        .k_out     (seq_k),
        .over_out  (seq_over),
        .alu_req   (alu_req),
        .alu_a     (alu_a),
        .alu_b     (alu_b),
        .alu_done  (alu_done),
        .alu_res   (alu_res)
    );

    fssum_alu #(
        .DW        (DW),
        .FRAC_BITS (FRAC_BITS)
    ) u_alu (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (alu_req),
        .a      (alu_a),
        .b      (alu_b),
        .done   (alu_done),
        .result (alu_res)
    );

    // sum back to q4.28 with saturation
    assign s_neg = seq_sum[DW];
    assign s_mag = s_neg ? (DW + 1)'(-seq_sum) : (DW + 1)'(seq_sum);
    assign o_dn  = (OCW'(s_mag) + OCW'(O_HALF)) >> O_DN;
    assign o_up  = OCW'(s_mag) << O_UP;
    assign o_mag = (FRAC_BITS >= IO_FRAC) ? o_dn : o_up;
    assign o_lim = s_neg ? SAT_NEG : SAT_POS;
    assign o_sat = (o_mag > o_lim) ? o_lim : o_mag;

    // output register frees up as soon as its transaction completes
    assign res_ready = !out_valid_reg || out_ready;
    assign res_take  = status.res_valid && res_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        sum_out_next   = sum_out_reg;
        terms_next     = terms_reg;
        nc_next        = nc_reg;
        if (res_take)
        begin
            out_valid_next = 1'b1;
            sum_out_next   = s_neg ? -(32'(o_sat)) : 32'(o_sat);
            terms_next     = 5'(seq_k);
            nc_next        = seq_over;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_out_reg <= sum_out_next;
        terms_reg   <= terms_next;
        nc_reg      <= nc_next;
    end

    assign out_valid     = out_valid_reg;
    assign series_sum    = sum_out_reg;
    assign terms_used    = terms_reg;
    assign not_converged = nc_reg;

    // an accepted item keeps the input side closed on the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input taken again right after an accepted item");

    // a non-converged result always used the full term budget
    a_nc_full_terms: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && not_converged) |-> (terms_used == 5'(MAX_TERMS)))
        else $error("not_converged without reaching the term limit");

    // the shared unit is only started while it has no answer pending
    a_alu_single_start: assert property (@(posedge clk) disable iff (!rst_n)
        alu_req.start |=> !alu_req.start)
        else $error("shared unit started twice in a row");

    // results leave the sequencer only into a free output register
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |-> !res_take)
        else $error("pending output overwritten");

endmodule

`default_nettype wire

// ===== sim/fssum_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fssum_checker
// watches the cfg, in and out channels of the fresnel sine series core,
// predicts each result and compares it field by field in arrival order
// ----------------------------------------------------------------------------

module fssum_checker #(
    parameter int MAX_TERMS = 16,
    parameter int FRAC_BITS = 28
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [27:0]        epsilon,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic signed [30:0] x_value,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic signed [31:0] series_sum,
    input  logic [4:0]         terms_used,
    input  logic               not_converged,
    output int                 fail_count,
    output int                 outstanding
);
    import fssum_pkg::*;

    typedef struct packed {
        logic signed [31:0] sum;
        logic [4:0]         terms;
        logic               over;
    } fresnel_result_t;

    fresnel_result_t expected_sums[$];
    logic [27:0]     eps_reg;

    function automatic longint unsigned magnitude(input longint v);
        return (v < 0) ? longint'(-v) : longint'(v);
    endfunction

    function automatic longint with_sign(input longint unsigned m, input logic neg);
        return neg ? -longint'(m) : longint'(m);
    endfunction

    // format change, exact to the left, rounded half away from zero to the right
    function automatic longint unsigned rescale(input longint unsigned m,
                                                input int src, input int dst);
        if (dst >= src)
            return m << (dst - src);
        return (m + (64'd1 << (src - dst - 1))) >> (src - dst);
    endfunction

    function automatic longint fx_product(input longint a, input longint b);
        logic [127:0] p;
        p = {64'd0, magnitude(a)} * {64'd0, magnitude(b)};
        p = (p + (128'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        return with_sign(p[63:0], (a < 0) != (b < 0));
    endfunction

    function automatic longint fx_quotient(input longint a, input longint unsigned d);
        longint unsigned m;
        longint unsigned q;
        longint unsigned r;
        m = magnitude(a);
        q = m / d;
        r = m % d;
        if (r >= d - r)
            q++;
        return with_sign(q, a < 0);
    endfunction

    function automatic fresnel_result_t fresnel_series_predict(input logic signed [30:0] xin,
                                                               input logic [27:0] eps_q28);
        fresnel_result_t res;
        longint          xv;
        longint          x;
        longint          x2;
        longint          x4;
        longint          term;
        longint          acc;
        longint          p;
        longint unsigned eps_i;
        longint unsigned m;
        longint unsigned kk;
        int              k;
        xv = longint'(xin);
        // argument beyond +-2.0 is clamped
        if (xv > X_LIMIT)
            xv = X_LIMIT;
        if (xv < -X_LIMIT)
            xv = -X_LIMIT;
        x     = with_sign(rescale(magnitude(xv), IO_FRAC, FRAC_BITS), xv < 0);
        eps_i = rescale(64'(eps_q28), IO_FRAC, FRAC_BITS);
        x2    = fx_product(x, x);
        x4    = fx_product(x2, x2);
        term  = fx_quotient(fx_product(x2, x), FIRST_DIV);
        acc   = term;
        k     = 0;
        while (magnitude(term) > eps_i && k < MAX_TERMS) begin
            k++;
            kk   = longint'(k);
            p    = fx_product(term, x4) * longint'(4 * kk - 1);
            term = -fx_quotient(p, (2 * kk) * (2 * kk + 1) * (4 * kk + 3));
            acc += term;
        end
        res.over  = magnitude(term) > eps_i;
        res.terms = 5'(k);
        // back to q4.28 with saturation
        m = rescale(magnitude(acc), FRAC_BITS, IO_FRAC);
        if (acc < 0) begin
            if (m > 64'h8000_0000)
                m = 64'h8000_0000;
            res.sum = 32'(-longint'(m));
        end
        else begin
            if (m > 64'h7FFF_FFFF)
                m = 64'h7FFF_FFFF;
            res.sum = 32'(m);
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        fresnel_result_t want;
        if (!rst_n) begin
            eps_reg     <= 28'(EPS_RESET);
            expected_sums.delete();
            fail_count  <= 0;
            outstanding <= 0;
        end
        else begin
            if (cfg_valid && cfg_ready)
                eps_reg <= epsilon;
            if (in_valid && in_ready)
                expected_sums.push_back(fresnel_series_predict(x_value, eps_reg));
            if (out_valid && out_ready) begin
                if (expected_sums.size() == 0) begin
                    $display("%0t: unexpected result sum=%0d terms=%0d nc=%0b",
                             $time, series_sum, terms_used, not_converged);
                    fail_count <= fail_count + 1;
                end
                else begin
                    want = expected_sums.pop_front();
                    if (want.sum !== series_sum || want.terms !== terms_used
                        || want.over !== not_converged) begin
                        if (want.sum !== series_sum)
                            $display("%0t: series_sum expected %0d actual %0d",
                                     $time, want.sum, series_sum);
                        if (want.terms !== terms_used)
                            $display("%0t: terms_used expected %0d actual %0d",
                                     $time, want.terms, terms_used);
                        if (want.over !== not_converged)
                            $display("%0t: not_converged expected %0b actual %0b",
                                     $time, want.over, not_converged);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            outstanding <= expected_sums.size();
        end
    end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// drives the fresnel sine series core with directed and random arguments
// under several epsilon settings and idle patterns; fssum_checker judges
// ----------------------------------------------------------------------------

module tb_top;
    import fssum_pkg::*;

    localparam int MAX_TERMS   = 16;
    localparam int FRAC_BITS   = 28;
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 170;
    // long receiver hold-off, well over one worst-case item
    localparam int HOLD_CYCLES = 3000;
    // roughly one worst-case item plus margin
    localparam int SETTLE      = 1000;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [27:0]        epsilon;
    logic               in_valid;
    logic               in_ready;
    logic signed [30:0] x_value;
    logic               out_valid;
    logic               out_ready;
    logic signed [31:0] series_sum;
    logic [4:0]         terms_used;
    logic               not_converged;

    int fail_count;
    int outstanding;

    // idle rates in percent, set per phase
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    // handshake between stimulus and the receiver for the long hold-off
    bit hold_request = 1'b0;
    bit hold_done    = 1'b0;

    always #4 clk = ~clk;

    fresnel_sine_series_sum_core #(
        .MAX_TERMS (MAX_TERMS),
        .FRAC_BITS (FRAC_BITS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .epsilon       (epsilon),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .x_value       (x_value),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .series_sum    (series_sum),
        .terms_used    (terms_used),
        .not_converged (not_converged)
    );

    fssum_checker #(
        .MAX_TERMS (MAX_TERMS),
        .FRAC_BITS (FRAC_BITS)
    ) u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .epsilon       (epsilon),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .x_value       (x_value),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .series_sum    (series_sum),
        .terms_used    (terms_used),
        .not_converged (not_converged),
        .fail_count    (fail_count),
        .outstanding   (outstanding)
    );

    // offer one argument; valid stays high until the transaction completes
    task automatic send_arg(input logic signed [30:0] x);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        x_value  <= x;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // stop offering and wait until every expected result has come back
    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    task automatic write_epsilon(input logic [27:0] value);
        cfg_valid <= 1'b1;
        epsilon   <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // random argument: mostly within +-2.0, some tiny, some over range to hit the clamp
    function automatic logic signed [30:0] random_arg();
        int unsigned pick;
        int          v;
        pick = $urandom_range(99);
        if (pick < 70)
            v = int'($urandom_range(2 * X_LIMIT)) - X_LIMIT;
        else if (pick < 85)
            v = int'($urandom_range(2 * X_LIMIT)) - X_LIMIT >>> $urandom_range(24);
        else
            v = int'($urandom());
        return 31'(v);
    endfunction

    // receiver: random stalls, plus one long hold-off on request
    initial
    begin : receiver
        int n;
        out_ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_request && !hold_done) begin
                out_ready <= 1'b0;
                for (n = 1; n < HOLD_CYCLES; n++)
                    @(posedge clk);
                hold_done = 1'b1;
            end
            else begin
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // run limit, far beyond the slowest legal run
    initial
    begin
        #80_000_000;
        $display("tb: failure");
        $finish;
    end

    initial
    begin : stimulus
        logic signed [30:0] corner_args[$];
        logic signed [30:0] zero_eps_args[$];
        logic [27:0]        eps_setting;
        int                 ph;
        int                 i;
        int                 waited;

        corner_args = '{31'sd0, 31'sd536870912, -31'sd536870912, 31'sd1073741823,
                        -31'sd1073741824, 31'sd1, -31'sd1, 31'sd536870911,
                        -31'sd536870911, 31'sd268435456, -31'sd268435456, 31'sd1000,
                        31'h1555_5555, 31'h2AAA_AAAA, 31'sd33554432};
        zero_eps_args = '{31'sd536870912, -31'sd536870912, 31'sd268435456, 31'sd1,
                          31'sd0};

        rst_n     <= 1'b0;
        cfg_valid <= 1'b0;
        epsilon   <= '0;
        in_valid  <= 1'b0;
        x_value   <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // corner arguments with the epsilon from reset
        foreach (corner_args[j])
            send_arg(corner_args[j]);

        for (ph = 0; ph < PHASES; ph++) begin
            drain_results();
            case (ph)
                0:       eps_setting = '0;
                1:       eps_setting = 28'hFFF_FFFF;
                2:       eps_setting = 28'd1;
                3:       eps_setting = 28'($urandom());
                4:       eps_setting = 28'(EPS_RESET);
                default: eps_setting = 28'($urandom_range(4096));
            endcase
            write_epsilon(eps_setting);

            // idle pattern: none, sender, receiver, both
            case (ph % 4)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 46; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 46; end
                default: begin send_idle_pct = 21; recv_stall_pct = 21; end
            endcase

            // zero epsilon: run until a term rounds to zero or the term limit is reached
            if (ph == 0)
                foreach (zero_eps_args[j])
                    send_arg(zero_eps_args[j]);

            // fill the core while the output side is held off
            if (ph == 2)
                hold_request = 1'b1;

            for (i = 0; i < PHASE_ITEMS; i++)
                send_arg(random_arg());
        end

        in_valid <= 1'b0;
        waited = 0;
        while (outstanding != 0 && waited < 200000) begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE) @(posedge clk);

        if (outstanding != 0)
            $display("%0t: %0d expected results never arrived", $time, outstanding);
        if (fail_count == 0 && outstanding == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
